// ===== src/mexp_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, cell control type and modular add for modular_exponentiation.
// -----------------------------------------------------------------------------
package mexp_pkg;

	localparam int W  = 64;
	localparam int CW = $clog2(W);

	typedef struct packed {
		logic load;
		logic step;
	} cell_ctl_t;

	// (a + b) mod m with a, b < m
	function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
		input logic [W-1:0] m);
		logic [W:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			if (s >= {1'b0, m}) s = s - {1'b0, m};
			add_mod = s[W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/mexp_cell.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// mexp_cell
// Bit-serial modular multiplier cell: a double-and-add step each cycle on step.
// -----------------------------------------------------------------------------
module mexp_cell
	import mexp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cell_ctl_t    ctl,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic [W-1:0] m,
	output logic      [W-1:0] r
);

	logic [W-1:0] a_q, b_q, r_q, dbl, nxt;

	assign dbl = add_mod(r_q, r_q, m);
	assign nxt = b_q[W-1] ? add_mod(dbl, a_q, m) : dbl;
	assign r   = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
		end else if (ctl.load) begin
			r_q <= '0;
		end else if (ctl.step) begin
			r_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= a;
			b_q <= b;
		end else if (ctl.step) begin
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

// ===== src/modular_exponentiation.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modular exponentiation core.
// -----------------------------------------------------------------------------
// Usage:
//   Write modulus (index 0) and exponent (index 1) on the cfg port while idle.
//   Each item on the s_ stream carries a base; the m_ stream returns
//   base^exponent mod modulus, one item per input item, in order.
//   Two multiplier cells (square and multiply) run side by side, each
//   doing one double-and-add step per cycle in RUN, 64 steps per modular
//   product. The base is first reduced by a multiply with one, then each of
//   the 64 exponent bits takes a square-and-multiply pass. A zero modulus
//   answers zero without a pass. One item is worked on at a time;
//   s_tready is high only while idle.
//   The result sits in an output register; if the receiver stalls the core
//   waits in its final state until the register frees up.
//   Reset: modulus 1, exponent 0, no item pending.
// -----------------------------------------------------------------------------
module modular_exponentiation
	import mexp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // base_value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // power_result
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam logic REG_MODULUS  = 1'b0;
	localparam logic REG_EXPONENT = 1'b1;

	typedef enum logic [2:0] {IDLE, RUN, NEXT, LOAD, FIN} state_t;

	state_t       state_q;
	logic [W-1:0] mod_q, exp_q, acc_q, sq_q;
	logic [CW-1:0] cnt_q, bit_q;
	logic         red_q, mv_q;
	logic [63:0]  out_q;
	cell_ctl_t    ctl;
	logic [W-1:0] one_mod, a_mul, b_mul, r_sq, r_mul;

	assign one_mod  = (mod_q == W'(1)) ? '0 : W'(1);
	assign s_tready = (state_q == IDLE);
	assign m_tvalid = mv_q;
	assign m_tdata  = out_q;

	assign ctl.load = (state_q == LOAD) || (state_q == IDLE && s_tvalid && mod_q != '0);
	assign ctl.step = (state_q == RUN);
	assign a_mul    = (state_q == IDLE) ? one_mod : acc_q;
	assign b_mul    = (state_q == IDLE) ? s_tdata[W-1:0] : sq_q;

	mexp_cell u_sq (.clk(clk), .arst_n(arst_n), .ctl(ctl), .a(sq_q), .b(sq_q),
		.m(mod_q), .r(r_sq));
	mexp_cell u_mul (.clk(clk), .arst_n(arst_n), .ctl(ctl), .a(a_mul), .b(b_mul),
		.m(mod_q), .r(r_mul));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q   <= W'(1);
			exp_q   <= '0;
			state_q <= IDLE;
			mv_q    <= 1'b0;
			cnt_q   <= '0;
			bit_q   <= '0;
			red_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODULUS:  mod_q <= cfg_data[W-1:0];
					REG_EXPONENT: exp_q <= cfg_data[W-1:0];
					default: ;
				endcase
			end
			if (mv_q && m_tready) mv_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						if (mod_q == '0) begin
							acc_q   <= '0;
							state_q <= FIN;
						end else begin
							red_q   <= 1'b1;
							cnt_q   <= '0;
							state_q <= RUN;
						end
					end
				end
				RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(W-1)) state_q <= NEXT;
				end
				NEXT: begin
					cnt_q <= '0;
					if (red_q) begin
						red_q   <= 1'b0;
						sq_q    <= r_mul;
						acc_q   <= one_mod;
						bit_q   <= '0;
						state_q <= LOAD;
					end else begin
						if (exp_q[bit_q]) acc_q <= r_mul;
						sq_q  <= r_sq;
						bit_q <= bit_q + 1'b1;
						state_q <= (bit_q == CW'(W-1)) ? FIN : LOAD;
					end
				end
				LOAD: state_q <= RUN;
				FIN: begin
					if (!mv_q || m_tready) begin
						out_q   <= 64'(acc_q);
						mv_q    <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
